// File: hw/rtl/mkps_pkg.sv
// ----------------------------------------------------------------------------
// mkps_pkg
// Shared constants and types of the multi-keyword payload search block.
// ----------------------------------------------------------------------------
package mkps_pkg;

  localparam int unsigned NUM_KEYWORDS = 8;
  localparam int unsigned KEY_BYTES    = 31;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned MATCH_W  = 4;
  localparam int unsigned LOADED_W = 4;
  localparam int unsigned KW_CNT_W = $clog2(NUM_KEYWORDS + 1);
  localparam int unsigned SLOT_W   = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
  localparam int unsigned FILL_W   = $clog2(KEY_BYTES + 1);
  localparam int unsigned OCC_W    = 3;

  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd2;

  localparam logic [BYTE_W-1:0] SEPARATOR = 8'h7C;
  localparam logic [BYTE_W-1:0] TEXT_END  = 8'h00;

  typedef logic [NUM_KEYWORDS-1:0][BYTE_W-1:0] kw_col_t;

  typedef struct packed {
    logic                    wshift;
    logic                    wdrop;
    logic                    kclear;
    logic [NUM_KEYWORDS-1:0] kshift;
  } cell_ctrl_t;

  typedef struct packed {
    logic [MATCH_W-1:0]  match_index;
    logic [LOADED_W-1:0] keywords_loaded;
    logic                load_error;
  } result_t;

endpackage

// File: hw/rtl/mkps_cell.sv
// ----------------------------------------------------------------------------
// mkps_cell
// One position of the search chain: a payload window byte and one keyword
// byte per slot, each shifting on to the next cell, plus the compare term.
// ----------------------------------------------------------------------------
module mkps_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mkps_pkg::cell_ctrl_t          ctrl_i,
  input  logic [mkps_pkg::BYTE_W-1:0]   wbyte_i,
  input  logic                          wvalid_i,
  input  mkps_pkg::kw_col_t             kbyte_i,
  input  logic [mkps_pkg::NUM_KEYWORDS-1:0] kvalid_i,
  input  logic [mkps_pkg::NUM_KEYWORDS-1:0] ok_i,
  output logic [mkps_pkg::BYTE_W-1:0]   wbyte_o,
  output logic                          wvalid_o,
  output mkps_pkg::kw_col_t             kbyte_o,
  output logic [mkps_pkg::NUM_KEYWORDS-1:0] kvalid_o,
  output logic [mkps_pkg::NUM_KEYWORDS-1:0] ok_o
);
  import mkps_pkg::*;

  logic [BYTE_W-1:0]       wbyte_q;
  logic                    wvalid_q, wvalid_d;
  kw_col_t                 kbyte_q, kbyte_d;
  logic [NUM_KEYWORDS-1:0] kvalid_q, kvalid_d;

  always_comb begin
    wvalid_d = wvalid_q;
    if (ctrl_i.wshift) begin
      wvalid_d = wvalid_i;
    end else if (ctrl_i.wdrop) begin
      wvalid_d = 1'b0;
    end
  end

  always_comb begin
    kbyte_d  = kbyte_q;
    kvalid_d = kvalid_q;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (ctrl_i.kshift[k]) begin
        kbyte_d[k]  = kbyte_i[k];
        kvalid_d[k] = kvalid_i[k];
      end
    end
    if (ctrl_i.kclear) begin
      kvalid_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wshift) begin
      wbyte_q <= wbyte_i;
    end
    kbyte_q <= kbyte_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q <= 1'b0;
      kvalid_q <= '0;
    end else begin
      wvalid_q <= wvalid_d;
      kvalid_q <= kvalid_d;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      ok_o[k] = ok_i[k] & (~kvalid_q[k] | (wvalid_q & (wbyte_q == kbyte_q[k])));
    end
  end

  assign wbyte_o  = wbyte_q;
  assign wvalid_o = wvalid_q & ~ctrl_i.wdrop;
  assign kbyte_o  = kbyte_q;
  assign kvalid_o = kvalid_q;

endmodule

// File: hw/rtl/mkps_result_q.sv
// ----------------------------------------------------------------------------
// mkps_result_q
// Two-entry result buffer: an output register backed by a skid register.
// ----------------------------------------------------------------------------
module mkps_result_q (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mkps_pkg::result_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output mkps_pkg::result_t data_o,
  output logic [1:0]        count_o
);
  import mkps_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = out_valid_q & ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q) begin
      out_valid_d = push_i;
      out_d       = data_i;
    end else if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = push_i;
        skid_d       = data_i;
      end else begin
        out_valid_d = push_i;
        out_d       = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;
  assign count_o = {1'b0, out_valid_q} + {1'b0, skid_valid_q};

endmodule

// File: hw/rtl/multi_keyword_payload_search.sv
// ----------------------------------------------------------------------------
// multi_keyword_payload_search
// Matches a loaded keyword list against streamed packet payload bytes.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_ready_o is high. Keyword text
// and payload bytes both shift into a chain of KEY_BYTES cells, and every
// keyword is compared against the window of recent payload bytes in the
// cycle after each payload byte. The result of a packet passes through
// eval_last_q into a two-entry result buffer and waits there; the input stalls
// only when that buffer would overflow because results are not being taken.
module multi_keyword_payload_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mkps_pkg::KIND_W-1:0]   kind_i,
  input  logic [mkps_pkg::BYTE_W-1:0]   value_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mkps_pkg::MATCH_W-1:0]  match_index_o,
  output logic [mkps_pkg::LOADED_W-1:0] keywords_loaded_o,
  output logic                          load_error_o
);
  import mkps_pkg::*;

  logic                    empty_all_q;
  logic [KW_CNT_W-1:0]     total_q, total_d;
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic                    text_seen_q, text_seen_d;
  logic                    ovf_q, ovf_d;
  logic [NUM_KEYWORDS-1:0] found_q, found_d;
  logic                    eval_q, eval_last_q;

  logic                    in_acc, clear_acc, text_acc, pay_acc;
  logic                    txt_store;
  cell_ctrl_t              ctrl;

  logic [KEY_BYTES:0][BYTE_W-1:0]       wbyte_c;
  logic [KEY_BYTES:0]                   wvalid_c;
  kw_col_t [KEY_BYTES:0]                kbyte_c;
  logic [KEY_BYTES:0][NUM_KEYWORDS-1:0] kvalid_c;
  logic [KEY_BYTES:0][NUM_KEYWORDS-1:0] ok_c;

  logic [NUM_KEYWORDS-1:0] slot_live, hits, found_new;
  logic [MATCH_W-1:0]      match_idx;
  result_t                 res;
  logic [1:0]              q_count;
  logic [OCC_W-1:0]        occ;
  logic                    pop;

  assign pop        = out_valid_o & out_ready_i;
  assign occ        = OCC_W'(q_count) + OCC_W'(eval_last_q) - OCC_W'(pop);
  assign in_ready_o = (occ <= OCC_W'(1));

  assign in_acc    = in_valid_i & in_ready_o;
  assign clear_acc = in_acc & (kind_i == KIND_CLEAR);
  assign text_acc  = in_acc & (kind_i == KIND_TEXT);
  assign pay_acc   = in_acc & (kind_i == KIND_PAYLOAD);

  assign txt_store = text_acc && (value_i != TEXT_END) && (value_i != SEPARATOR) &&
                     (fill_q < FILL_W'(KEY_BYTES)) && (total_q < KW_CNT_W'(NUM_KEYWORDS));

  always_comb begin
    ctrl.wshift = pay_acc;
    ctrl.wdrop  = eval_last_q | clear_acc;
    ctrl.kclear = clear_acc;
    ctrl.kshift = '0;
    if (txt_store) begin
      ctrl.kshift = NUM_KEYWORDS'(1) << total_q[SLOT_W-1:0];
    end
  end

  always_comb begin
    total_d     = total_q;
    fill_d      = fill_q;
    text_seen_d = text_seen_q;
    ovf_d       = ovf_q;
    if (clear_acc) begin
      total_d     = '0;
      fill_d      = '0;
      text_seen_d = 1'b0;
      ovf_d       = 1'b0;
    end else if (text_acc) begin
      if (value_i == TEXT_END) begin
        text_seen_d = 1'b0;
        if (text_seen_q) begin
          fill_d = '0;
          if (total_q < KW_CNT_W'(NUM_KEYWORDS)) begin
            total_d = total_q + KW_CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end else begin
        text_seen_d = 1'b1;
        if (value_i == SEPARATOR) begin
          fill_d = '0;
          if (total_q < KW_CNT_W'(NUM_KEYWORDS)) begin
            total_d = total_q + KW_CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end else if (fill_q >= FILL_W'(KEY_BYTES)) begin
          ovf_d = 1'b1;
        end else begin
          fill_d = fill_q + FILL_W'(1);
        end
      end
    end
  end

  assign wbyte_c[0]  = value_i;
  assign wvalid_c[0] = 1'b1;
  assign kbyte_c[0]  = {NUM_KEYWORDS{value_i}};
  assign kvalid_c[0] = '1;
  assign ok_c[0]     = '1;

  for (genvar i = 0; i < KEY_BYTES; i++) begin : g_cell
    mkps_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .wbyte_i  (wbyte_c[i]),
      .wvalid_i (wvalid_c[i]),
      .kbyte_i  (kbyte_c[i]),
      .kvalid_i (kvalid_c[i]),
      .ok_i     (ok_c[i]),
      .wbyte_o  (wbyte_c[i+1]),
      .wvalid_o (wvalid_c[i+1]),
      .kbyte_o  (kbyte_c[i+1]),
      .kvalid_o (kvalid_c[i+1]),
      .ok_o     (ok_c[i+1])
    );
  end

  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      slot_live[k] = (KW_CNT_W'(k) < total_q);
    end
  end

  assign hits      = {NUM_KEYWORDS{eval_q}} & ok_c[KEY_BYTES] & kvalid_c[1] & slot_live;
  assign found_new = found_q | hits;

  always_comb begin
    match_idx = '0;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (found_new[k]) begin
        match_idx = MATCH_W'(k + 1);
      end
    end
    if (total_q == '0) begin
      match_idx = MATCH_W'(empty_all_q);
    end
  end

  always_comb begin
    found_d = found_new;
    if (clear_acc || eval_last_q) begin
      found_d = '0;
    end
  end

  assign res.match_index     = match_idx;
  assign res.keywords_loaded = LOADED_W'(total_q);
  assign res.load_error      = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_all_q <= 1'b1;
      total_q     <= '0;
      fill_q      <= '0;
      text_seen_q <= 1'b0;
      ovf_q       <= 1'b0;
      found_q     <= '0;
      eval_q      <= 1'b0;
      eval_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        empty_all_q <= cfg_wdata_i;
      end
      total_q     <= total_d;
      fill_q      <= fill_d;
      text_seen_q <= text_seen_d;
      ovf_q       <= ovf_d;
      found_q     <= found_d;
      eval_q      <= pay_acc;
      eval_last_q <= pay_acc & last_i;
    end
  end

  mkps_result_q u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (eval_last_q),
    .data_i  (res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  ({match_index_o, keywords_loaded_o, load_error_o}),
    .count_o (q_count)
  );

endmodule

// File: hw/rtl/mkps_checker.sv
// ----------------------------------------------------------------------------
// mkps_checker
// Port-level checks of the multi-keyword payload search block.
// ----------------------------------------------------------------------------
module mkps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic                          cfg_wdata_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [mkps_pkg::KIND_W-1:0]   kind_i,
  input logic [mkps_pkg::BYTE_W-1:0]   value_i,
  input logic                          last_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [mkps_pkg::MATCH_W-1:0]  match_index_o,
  input logic [mkps_pkg::LOADED_W-1:0] keywords_loaded_o,
  input logic                          load_error_o
);
  import mkps_pkg::*;

  logic cfg_unused;
  assign cfg_unused = cfg_we_i ^ cfg_wdata_i ^ (^value_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_index_o) &&
    $stable(keywords_loaded_o) && $stable(load_error_o))
    else $error("Result changed while stalled.");

  a_loaded_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> keywords_loaded_o <= LOADED_W'(NUM_KEYWORDS))
    else $error("Keyword count out of range.");

  a_match_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (match_index_o <= MATCH_W'(keywords_loaded_o)) ||
    (keywords_loaded_o == '0 && match_index_o == MATCH_W'(1)))
    else $error("Match index beyond the loaded keywords.");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_i &&
    kind_i == KIND_PAYLOAD && !cfg_unused || in_valid_i && in_ready_o && last_i &&
    kind_i == KIND_PAYLOAD && cfg_unused, 2))
    else $error("Result without a final payload item.");

endmodule

bind multi_keyword_payload_search mkps_checker u_mkps_checker (.*);

// File: tb/sv/keyword_match_checker.sv
// ----------------------------------------------------------------------------
// keyword_match_checker
// Watches both channels of the keyword search, predicts each packet's verdict
// from the accepted items and compares it with the result that comes out.
// ----------------------------------------------------------------------------
module keyword_match_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [mkps_pkg::KIND_W-1:0]   kind_i,
  input  logic [mkps_pkg::BYTE_W-1:0]   value_i,
  input  logic                          last_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [mkps_pkg::MATCH_W-1:0]  match_index_i,
  input  logic [mkps_pkg::LOADED_W-1:0] keywords_loaded_i,
  input  logic                          load_error_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   verdicts_pending_o
);
  import mkps_pkg::*;

  logic [BYTE_W-1:0]       kw_text [NUM_KEYWORDS][KEY_BYTES];
  logic [FILL_W-1:0]       kw_len [NUM_KEYWORDS];
  logic [KW_CNT_W-1:0]     kw_count;
  logic [FILL_W-1:0]       fill_pos;
  logic                    text_open;
  logic                    list_overflow;
  logic [BYTE_W-1:0]       window [KEY_BYTES];
  logic [FILL_W-1:0]       window_fill;
  logic [NUM_KEYWORDS-1:0] found;
  logic                    empty_list_hits;
  result_t                 expected_verdicts [$];

  task automatic drop_packet();
    for (int i = 0; i < KEY_BYTES; i++) window[i] = '0;
    window_fill = '0;
    found = '0;
  endtask

  task automatic clear_list();
    for (int k = 0; k < NUM_KEYWORDS; k++) kw_len[k] = '0;
    kw_count = '0;
    fill_pos = '0;
    text_open = 1'b0;
    list_overflow = 1'b0;
    drop_packet();
  endtask

  task automatic close_keyword();
    if (kw_count < NUM_KEYWORDS) begin
      kw_len[kw_count] = fill_pos;
      kw_count++;
    end else begin
      list_overflow = 1'b1;
    end
    fill_pos = '0;
  endtask

  task automatic take_text(input logic [BYTE_W-1:0] b);
    if (b == TEXT_END) begin
      if (text_open) close_keyword();
      text_open = 1'b0;
    end else begin
      text_open = 1'b1;
      if (b == SEPARATOR) begin
        close_keyword();
      end else if (fill_pos >= KEY_BYTES) begin
        list_overflow = 1'b1;
      end else begin
        if (kw_count < NUM_KEYWORDS) kw_text[kw_count][fill_pos] = b;
        fill_pos++;
      end
    end
  endtask

  function automatic logic keyword_ends_here(input int k);
    int len;
    len = kw_len[k];
    if (len == 0 || len > window_fill) return 1'b0;
    for (int j = 0; j < len; j++) begin
      if (kw_text[k][j] != window[len-1-j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic take_payload(input logic [BYTE_W-1:0] b, input logic l);
    result_t verdict;
    for (int i = KEY_BYTES - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = b;
    if (window_fill < KEY_BYTES) window_fill++;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (k < kw_count && keyword_ends_here(k)) found[k] = 1'b1;
    end
    if (l) begin
      verdict.match_index = '0;
      if (kw_count == 0) begin
        verdict.match_index = empty_list_hits ? MATCH_W'(1) : MATCH_W'(0);
      end else begin
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
          if (k < kw_count && found[k]) verdict.match_index = MATCH_W'(k + 1);
        end
      end
      verdict.keywords_loaded = LOADED_W'(kw_count);
      verdict.load_error = list_overflow;
      expected_verdicts.push_back(verdict);
      drop_packet();
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
        for (int j = 0; j < KEY_BYTES; j++) kw_text[k][j] = '0;
      end
      clear_list();
      empty_list_hits = 1'b1;
      expected_verdicts.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) empty_list_hits = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d", $time,
                   match_index_i, keywords_loaded_i, load_error_i);
          mismatch_count_o++;
        end else begin
          want = expected_verdicts.pop_front();
          compare_field("match_index", want.match_index, match_index_i);
          compare_field("keywords_loaded", want.keywords_loaded, keywords_loaded_i);
          compare_field("load_error", want.load_error, load_error_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (kind_i)
          KIND_CLEAR: begin
            clear_list();
          end
          KIND_TEXT: begin
            take_text(value_i);
          end
          KIND_PAYLOAD: begin
            take_payload(value_i, last_i);
          end
          default: begin
          end
        endcase
      end
    end
    verdicts_pending_o <= expected_verdicts.size();
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives keyword lists and packets into the keyword search with random gaps
// and output stalls, and reports the verdict of the checker beside it.
// ----------------------------------------------------------------------------
module testbench;
  import mkps_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned QUIET_FROM   = 1400;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned BANK_SLOTS   = 12;
  localparam int unsigned BANK_BYTES   = 40;
  localparam int unsigned PKT_BYTES    = 48;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic [KIND_W-1:0]   kind_i      = KIND_CLEAR;
  logic [BYTE_W-1:0]   value_i     = '0;
  logic                last_i      = 1'b0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [MATCH_W-1:0]  match_index_o;
  logic [LOADED_W-1:0] keywords_loaded_o;
  logic                load_error_o;

  int unsigned mismatch_count;
  int unsigned verdicts_pending;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned stall_left  = 0;

  logic [BYTE_W-1:0] kw_bank [BANK_SLOTS][BANK_BYTES];
  int unsigned       kw_bank_len [BANK_SLOTS];
  int unsigned       kw_bank_count = 0;

  multi_keyword_payload_search u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .value_i           (value_i),
    .last_i            (last_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .match_index_o     (match_index_o),
    .keywords_loaded_o (keywords_loaded_o),
    .load_error_o      (load_error_o)
  );

  keyword_match_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .kind_i             (kind_i),
    .value_i            (value_i),
    .last_i             (last_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .match_index_i      (match_index_o),
    .keywords_loaded_i  (keywords_loaded_o),
    .load_error_i       (load_error_o),
    .mismatch_count_o   (mismatch_count),
    .verdicts_pending_o (verdicts_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 13);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] v,
                           input logic l);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    value_i <= v;
    last_i <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (k != KIND_UNUSED) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdicts_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_clear();
    send_item(KIND_CLEAR, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    kw_bank_count = 0;
  endtask

  function automatic logic [BYTE_W-1:0] keyword_byte();
    int unsigned r;
    logic [BYTE_W-1:0] b;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'h61 + BYTE_W'(r % 3);
    b = BYTE_W'($urandom_range(1, 255));
    return (b == SEPARATOR) ? 8'h7D : b;
  endfunction

  function automatic logic [BYTE_W-1:0] payload_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'h61 + BYTE_W'(r % 3);
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic load_list();
    int unsigned n;
    int unsigned len;
    logic [BYTE_W-1:0] b;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 36) : $urandom_range(1, 4);
      for (int j = 0; j < len; j++) begin
        b = keyword_byte();
        if (kw_bank_count < BANK_SLOTS) kw_bank[kw_bank_count][j] = b;
        send_item(KIND_TEXT, b, 1'($urandom_range(0, 1)));
      end
      if (kw_bank_count < BANK_SLOTS) begin
        kw_bank_len[kw_bank_count] = len;
        kw_bank_count++;
      end
      send_item(KIND_TEXT, $urandom_range(0, 1) ? SEPARATOR : TEXT_END,
                1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) send_item(KIND_TEXT, TEXT_END, 1'b0);
      if ($urandom_range(0, 19) == 0) send_item(KIND_TEXT, SEPARATOR, 1'b0);
    end
  endtask

  task automatic send_packet();
    logic [BYTE_W-1:0] pkt [PKT_BYTES];
    int unsigned len;
    int unsigned k;
    int unsigned pos;
    int unsigned r;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, PKT_BYTES) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) pkt[i] = payload_byte();
    if (kw_bank_count != 0 && $urandom_range(0, 9) < 6) begin
      k = $urandom_range(0, kw_bank_count - 1);
      if (kw_bank_len[k] <= len) begin
        pos = $urandom_range(0, len - kw_bank_len[k]);
        for (int j = 0; j < kw_bank_len[k]; j++) pkt[pos+j] = kw_bank[k][j];
      end
    end
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 199);
      if (r == 0) begin
        send_clear();
      end else if (r < 5) begin
        send_item(KIND_UNUSED, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (r < 8) begin
        send_item(KIND_TEXT, keyword_byte(), 1'($urandom_range(0, 1)));
      end
      send_item(KIND_PAYLOAD, pkt[i], i == len - 1);
    end
  endtask

  initial begin
    int unsigned episode;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty list in both modes, separators, lone zeros,
    // ignored kinds, a clear inside a packet and a full list.
    send_item(KIND_PAYLOAD, 8'h00, 1'b1);
    wait_drained();
    write_mode(1'b0);
    send_item(KIND_PAYLOAD, 8'hFF, 1'b1);
    send_item(KIND_TEXT, 8'h61, 1'b0);
    send_item(KIND_TEXT, 8'h62, 1'b0);
    send_item(KIND_TEXT, SEPARATOR, 1'b0);
    send_item(KIND_TEXT, TEXT_END, 1'b0);
    send_item(KIND_TEXT, TEXT_END, 1'b0);
    send_item(KIND_TEXT, 8'hFF, 1'b0);
    send_item(KIND_TEXT, TEXT_END, 1'b0);
    send_item(KIND_UNUSED, 8'hAA, 1'b1);
    send_item(KIND_TEXT, 8'h63, 1'b1);
    send_item(KIND_PAYLOAD, 8'h61, 1'b0);
    send_item(KIND_PAYLOAD, 8'h62, 1'b0);
    send_item(KIND_PAYLOAD, 8'hFF, 1'b1);
    send_item(KIND_PAYLOAD, 8'h61, 1'b0);
    send_item(KIND_CLEAR, 8'h00, 1'b0);
    send_item(KIND_PAYLOAD, 8'h62, 1'b1);
    wait_drained();
    write_mode(1'b1);
    send_item(KIND_PAYLOAD, 8'h55, 1'b1);
    repeat (NUM_KEYWORDS + 1) send_item(KIND_TEXT, SEPARATOR, 1'b0);
    send_item(KIND_PAYLOAD, SEPARATOR, 1'b1);
    send_clear();

    episode = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      episode++;
      if (episode % 6 == 0) begin
        wait_drained();
        write_mode(1'($urandom_range(0, 1)));
      end
      if (items_sent >= QUIET_FROM) begin
        gap_pct = 0;
        stall_pct <= 0;
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            gap_pct = 0;
            stall_pct <= 0;
          end
          1: begin
            gap_pct = 8;
            stall_pct <= 5;
          end
          default: begin
            gap_pct = 30;
            stall_pct <= 20;
          end
        endcase
      end
      if ($urandom_range(0, 3) != 0) send_clear();
      load_list();
      repeat ($urandom_range(1, 6)) send_packet();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(KIND_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && verdicts_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
